FILE: rtl/dspt_pkg.sv
// Package for the dual stopwatch / presence timer: types, codes and constants.
// Used by dspt_chan, dspt_presence, the top level and the testbench; depends on nothing.
package dspt_pkg;

   localparam int NUM_CHANNELS_DEF = 2;
   localparam int NUM_CHANNELS_MAX = 8;

   localparam logic [31:0] PING_GRACE_MS = 32'd500;

   localparam logic [15:0] PING_INTERVAL_RST  = 16'd1000;
   localparam logic [15:0] TOGGLE_LOCKOUT_RST = 16'd500;
   localparam logic [15:0] MIN_RUN_RST        = 16'd5000;
   localparam logic [31:0] IDLE_RESET_RST     = 32'd300000;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PING_INTERVAL  = 2'd0,
      CSR_TOGGLE_LOCKOUT = 2'd1,
      CSR_MIN_RUN        = 2'd2,
      CSR_IDLE_RESET     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FUNC_TICK   = 3'd0,
      FUNC_TOGGLE = 3'd1,
      FUNC_SET    = 3'd2,
      FUNC_RESET  = 3'd3,
      FUNC_PING   = 3'd4
   } func_type;

   typedef struct packed {
      logic [15:0] ping_interval;
      logic [15:0] toggle_lockout;
      logic [15:0] min_run;
      logic [31:0] idle_reset;
   } cfg_type;

   // per-channel command, already qualified for that channel
   typedef struct packed {
      logic tick;
      logic toggle;
      logic set_go;
      logic set_stop;
      logic clear;
   } chan_cmd_type;

   typedef struct packed {
      logic tick;
      logic ping;
      logic ping_ch;
      logic ping_stop;
      logic ping_wait;
   } pres_cmd_type;

endpackage

FILE: rtl/dspt_req_if.sv
// Request channel: valid/ready handshake with the command fields of one transaction.
// Standalone; no package needed.
interface dspt_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic       channel;
   logic       stop_req;
   logic       waiting;
   logic       all_channels;

   modport source (output valid, func, channel, stop_req, waiting, all_channels,
                   input ready);
   modport sink   (input valid, func, channel, stop_req, waiting, all_channels,
                   output ready);
endinterface

FILE: rtl/dspt_rsp_if.sv
// Response channel: valid/ready handshake with the status fields of one transaction.
// Standalone; no package needed.
interface dspt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  running_mask;
   logic [31:0] time_ch0;
   logic [31:0] time_ch1;
   logic [3:0]  present_mask;
   logic [3:0]  waiting_mask;

   modport source (output valid, running_mask, time_ch0, time_ch1, present_mask,
                   waiting_mask, input ready);
   modport sink   (input valid, running_mask, time_ch0, time_ch1, present_mask,
                   waiting_mask, output ready);
endinterface

FILE: rtl/dspt_chan.sv
// One stopwatch channel: run flag, stamps, result, toggle lockout and idle clear.
// Depends on dspt_pkg.
module dspt_chan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dspt_pkg::chan_cmd_type cmd,
   input  dspt_pkg::cfg_type     cfg,
   input  logic [31:0]           now_cur,
   input  logic [31:0]           now_new,
   output logic                  running,
   output logic [31:0]           elapsed
);
   import dspt_pkg::*;

   logic        run_ff, run_in;
   logic        stop_valid_ff, stop_valid_in;
   logic        toggle_seen_ff, toggle_seen_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] result_ff, result_in;
   logic [31:0] stop_stamp_ff, stop_stamp_in;
   logic [31:0] last_toggle_ff, last_toggle_in;

   logic [31:0] run_len;
   logic [31:0] idle_len;
   logic [31:0] since_toggle;
   logic        lock_ok;
   logic        toggle_ok;
   logic        do_start;
   logic        do_stop;
   logic        do_clear;

   assign run_len      = now_cur - start_ff;
   assign idle_len     = now_new - stop_stamp_ff;
   assign since_toggle = now_cur - last_toggle_ff;
   assign lock_ok      = !toggle_seen_ff || (since_toggle >= {16'd0, cfg.toggle_lockout});
   assign toggle_ok    = cmd.toggle && lock_ok;

   assign do_start = (toggle_ok || cmd.set_go) && !run_ff;
   assign do_stop  = run_ff && (toggle_ok ||
                     (cmd.set_stop && (run_len >= {16'd0, cfg.min_run})));
   assign do_clear = cmd.clear || (cmd.tick && stop_valid_ff && (idle_len > cfg.idle_reset));

   always_comb begin
      run_in         = run_ff;
      stop_valid_in  = stop_valid_ff;
      start_in       = start_ff;
      result_in      = result_ff;
      stop_stamp_in  = stop_stamp_ff;
      toggle_seen_in = toggle_seen_ff || toggle_ok;
      last_toggle_in = toggle_ok ? now_cur : last_toggle_ff;
      priority if (do_start) begin
         run_in        = 1'b1;
         start_in      = now_cur;
         stop_valid_in = 1'b0;
      end else if (do_stop) begin
         run_in        = 1'b0;
         result_in     = run_len;
         stop_stamp_in = now_cur;
         stop_valid_in = 1'b1;
      end else if (do_clear) begin
         run_in        = 1'b0;
         result_in     = 32'd0;
         stop_valid_in = 1'b0;
      end
   end

   // status after this transaction
   assign running = run_in;
   assign elapsed = do_start ? 32'd0 : (run_in ? (now_new - start_ff) : result_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff         <= 1'b0;
         stop_valid_ff  <= 1'b0;
         toggle_seen_ff <= 1'b0;
         start_ff       <= 32'd0;
         result_ff      <= 32'd0;
         stop_stamp_ff  <= 32'd0;
         last_toggle_ff <= 32'd0;
      end else if (step) begin
         run_ff         <= run_in;
         stop_valid_ff  <= stop_valid_in;
         toggle_seen_ff <= toggle_seen_in;
         start_ff       <= start_in;
         result_ff      <= result_in;
         stop_stamp_ff  <= stop_stamp_in;
         last_toggle_ff <= last_toggle_in;
      end
   end

endmodule

FILE: rtl/dspt_presence.sv
// Presence watchdogs: per-slot ping stamp, alive and waiting flags plus the periodic check.
// Depends on dspt_pkg.
module dspt_presence #(
   parameter int NUM_SLOTS = 2 * dspt_pkg::NUM_CHANNELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  dspt_pkg::pres_cmd_type cmd,
   input  dspt_pkg::cfg_type      cfg,
   input  logic [31:0]            now_cur,
   input  logic [31:0]            now_new,
   output logic [NUM_SLOTS-1:0]   alive,
   output logic [NUM_SLOTS-1:0]   waiting
);
   import dspt_pkg::*;

   logic [NUM_SLOTS-1:0] alive_ff, alive_in;
   logic [NUM_SLOTS-1:0] waiting_ff, waiting_in;
   logic [31:0]          stamp_ff [NUM_SLOTS];
   logic [31:0]          last_check_ff;
   logic                 check_seen_ff;

   logic [31:0] limit;
   logic [31:0] since_check;
   logic        check_due;
   logic [NUM_SLOTS-1:0] hit;
   logic [31:0] age [NUM_SLOTS];

   assign limit       = {16'd0, cfg.ping_interval} + PING_GRACE_MS;
   assign since_check = now_new - last_check_ff;
   assign check_due   = cmd.tick && (!check_seen_ff || (since_check >= {16'd0, cfg.ping_interval}));

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
      localparam logic SLOT_CH   = ((i / 2) % 2) == 1;
      localparam logic SLOT_STOP = (i % 2) == 1;

      assign hit[i] = cmd.ping && (cmd.ping_ch == SLOT_CH) && (cmd.ping_stop == SLOT_STOP)
                      && ((i / 2) < 2);
      assign age[i] = now_new - stamp_ff[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            stamp_ff[i] <= 32'd0;
         end else if (step && hit[i]) begin
            stamp_ff[i] <= now_cur;
         end
      end
   end

   always_comb begin
      alive_in   = alive_ff;
      waiting_in = waiting_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (hit[i]) begin
            alive_in[i]   = 1'b1;
            waiting_in[i] = cmd.ping_wait;
         end else if (check_due && alive_ff[i] && (age[i] > limit)) begin
            alive_in[i] = 1'b0;
         end
      end
   end

   assign alive   = alive_in;
   assign waiting = waiting_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff      <= '0;
         waiting_ff    <= '0;
         last_check_ff <= 32'd0;
         check_seen_ff <= 1'b0;
      end else if (step) begin
         alive_ff   <= alive_in;
         waiting_ff <= waiting_in;
         if (check_due) begin
            last_check_ff <= now_new;
            check_seen_ff <= 1'b1;
         end
      end
   end

endmodule

FILE: rtl/dual_stopwatch_presence_timer_unit.sv
// Dual stopwatch with presence watchdogs. One transaction is accepted per clock while the
// response side keeps up, and each produces one status transaction. A request is captured
// in an input register, the state update and status are worked out from it and held in an
// output register once that register is free or being taken; the single input register
// plus the output register let a new request enter while a finished status waits.
// Depends on dspt_pkg, dspt_req_if, dspt_rsp_if, dspt_chan and dspt_presence.
module dual_stopwatch_presence_timer_unit #(
   parameter int NUM_CHANNELS = dspt_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dspt_req_if.sink                             req_bus,
   dspt_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [dspt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dspt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dspt_pkg::*;

   localparam int NUM_SLOTS = 2 * NUM_CHANNELS;
   localparam int OUT_CH    = (NUM_CHANNELS < 2) ? NUM_CHANNELS : 2;
   localparam int OUT_SLOTS = (NUM_SLOTS < 4) ? NUM_SLOTS : 4;

   // configuration
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ping_interval  <= PING_INTERVAL_RST;
         cfg_ff.toggle_lockout <= TOGGLE_LOCKOUT_RST;
         cfg_ff.min_run        <= MIN_RUN_RST;
         cfg_ff.idle_reset     <= IDLE_RESET_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PING_INTERVAL:  cfg_ff.ping_interval  <= csr_wdata[15:0];
            CSR_TOGGLE_LOCKOUT: cfg_ff.toggle_lockout <= csr_wdata[15:0];
            CSR_MIN_RUN:        cfg_ff.min_run        <= csr_wdata[15:0];
            CSR_IDLE_RESET:     cfg_ff.idle_reset     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // input register
   logic       in_vld_ff;
   logic [2:0] in_func_ff;
   logic       in_ch_ff;
   logic       in_stop_ff;
   logic       in_wait_ff;
   logic       in_all_ff;
   logic       out_vld_ff;
   logic       step;
   logic       req_take;

   assign step     = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !in_vld_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_vld_ff <= req_bus.valid;
      end
      if (req_take) begin
         in_func_ff <= req_bus.func;
         in_ch_ff   <= req_bus.channel;
         in_stop_ff <= req_bus.stop_req;
         in_wait_ff <= req_bus.waiting;
         in_all_ff  <= req_bus.all_channels;
      end
   end

   // millisecond counter, with its successor held ready
   logic [31:0] now_ff, now_p1_ff;
   logic [31:0] now_new;
   logic        is_tick;

   assign now_new = is_tick ? now_p1_ff : now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff    <= 32'd0;
         now_p1_ff <= 32'd1;
      end else if (step && is_tick) begin
         now_ff    <= now_p1_ff;
         now_p1_ff <= now_p1_ff + 32'd1;
      end
   end

   // decode
   logic is_toggle, is_set, is_reset, is_ping;
   logic ch_ok;

   assign ch_ok = 32'(in_ch_ff) < NUM_CHANNELS;

   always_comb begin
      is_tick   = 1'b0;
      is_toggle = 1'b0;
      is_set    = 1'b0;
      is_reset  = 1'b0;
      is_ping   = 1'b0;
      unique case (func_type'(in_func_ff))
         FUNC_TICK:   is_tick   = 1'b1;
         FUNC_TOGGLE: is_toggle = 1'b1;
         FUNC_SET:    is_set    = 1'b1;
         FUNC_RESET:  is_reset  = 1'b1;
         FUNC_PING:   is_ping   = 1'b1;
         default: ;
      endcase
   end

   logic              run_vec [NUM_CHANNELS];
   logic [31:0]       time_vec [NUM_CHANNELS];

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      chan_cmd_type ccmd;
      logic         sel;

      assign sel           = ch_ok && (32'(in_ch_ff) == c);
      assign ccmd.tick     = is_tick;
      assign ccmd.toggle   = is_toggle && sel;
      assign ccmd.set_go   = is_set && sel && !in_stop_ff;
      assign ccmd.set_stop = is_set && sel && in_stop_ff;
      assign ccmd.clear    = is_reset && (in_all_ff || sel);

      dspt_chan u_chan (
         .clock   (clock),
         .reset   (reset),
         .step    (step),
         .cmd     (ccmd),
         .cfg     (cfg_ff),
         .now_cur (now_ff),
         .now_new (now_new),
         .running (run_vec[c]),
         .elapsed (time_vec[c])
      );
   end

   pres_cmd_type         pcmd;
   logic [NUM_SLOTS-1:0] alive;
   logic [NUM_SLOTS-1:0] waiting;

   assign pcmd.tick      = is_tick;
   assign pcmd.ping      = is_ping && ch_ok;
   assign pcmd.ping_ch   = in_ch_ff;
   assign pcmd.ping_stop = in_stop_ff;
   assign pcmd.ping_wait = in_wait_ff;

   dspt_presence #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_presence (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .cmd     (pcmd),
      .cfg     (cfg_ff),
      .now_cur (now_ff),
      .now_new (now_new),
      .alive   (alive),
      .waiting (waiting)
   );

   // status words
   logic [1:0]  run_mask;
   logic [31:0] time_out [2];
   logic [3:0]  pres_mask;
   logic [3:0]  wait_mask;

   always_comb begin
      run_mask    = '0;
      time_out[0] = 32'd0;
      time_out[1] = 32'd0;
      pres_mask   = '0;
      wait_mask   = '0;
      for (int i = 0; i < OUT_CH; i++) begin
         run_mask[i] = run_vec[i];
         time_out[i] = time_vec[i];
      end
      for (int n = 0; n < OUT_SLOTS; n++) begin
         pres_mask[n] = alive[n];
         wait_mask[n] = alive[n] && waiting[n];
      end
   end

   // output register
   logic [1:0]  run_mask_ff;
   logic [31:0] time0_ff, time1_ff;
   logic [3:0]  pres_mask_ff, wait_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (step) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_ff <= 1'b0;
      end
      if (step) begin
         run_mask_ff  <= run_mask;
         time0_ff     <= time_out[0];
         time1_ff     <= time_out[1];
         pres_mask_ff <= pres_mask;
         wait_mask_ff <= wait_mask;
      end
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.running_mask = run_mask_ff;
   assign rsp_bus.time_ch0     = time0_ff;
   assign rsp_bus.time_ch1     = time1_ff;
   assign rsp_bus.present_mask = pres_mask_ff;
   assign rsp_bus.waiting_mask = wait_mask_ff;

endmodule

FILE: rtl/dspt_checker.sv
// Port-level checks for the dual stopwatch / presence timer, bound to its top level.
// Depends only on the top level's ports.
module dspt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  running_mask,
   input logic [31:0] time_ch0,
   input logic [31:0] time_ch1,
   input logic [3:0]  present_mask,
   input logic [3:0]  waiting_mask
);

   // a status stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("status dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(running_mask) && $stable(time_ch0)
         && $stable(time_ch1) && $stable(present_mask) && $stable(waiting_mask))
      else $error("stalled status changed");

   a_wait_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((waiting_mask & ~present_mask) == 4'd0))
      else $error("waiting reported for a slot that is not alive");

   // every accepted request is followed by an offered status
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no status after an accepted request");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("status offered straight after reset");

endmodule

bind dual_stopwatch_presence_timer_unit dspt_checker u_dspt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .running_mask (rsp_bus.running_mask),
   .time_ch0     (rsp_bus.time_ch0),
   .time_ch1     (rsp_bus.time_ch1),
   .present_mask (rsp_bus.present_mask),
   .waiting_mask (rsp_bus.waiting_mask)
);

FILE: sim/tb_dual_stopwatch_presence_timer_unit.sv
// Self-checking testbench for dual_stopwatch_presence_timer_unit: a queue-fed driver,
// a status monitor and a transaction-level prediction of both stopwatches and presence slots.
// Depends on dspt_pkg, dspt_req_if, dspt_rsp_if and the block itself.
module tb_dual_stopwatch_presence_timer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import dspt_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int DRAIN_CYCLES    = 6;

   // func codes above FUNC_PING have no action
   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0] func;
      logic       channel;
      logic       stop_req;
      logic       waiting;
      logic       all_channels;
   } stopwatch_cmd_type;

   typedef struct packed {
      logic [1:0]  running_mask;
      logic [31:0] time_ch0;
      logic [31:0] time_ch1;
      logic [3:0]  present_mask;
      logic [3:0]  waiting_mask;
   } status_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dspt_req_if req_if();
   dspt_rsp_if rsp_if();

   dual_stopwatch_presence_timer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6ns clock = ~clock;

   // stimulus and scoreboard
   stopwatch_cmd_type cmd_q[$];
   status_type        expected_status_q[$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   bit                hold_off_request = 1'b0;
   int                hold_left = 0;
   bit                req_taken = 1'b0;
   stopwatch_cmd_type next_cmd;
   stopwatch_cmd_type taken_cmd;
   status_type        got_status;
   status_type        want_status;

   // predicted configuration and state
   logic [15:0] cfg_ping_interval;
   logic [15:0] cfg_toggle_lockout;
   logic [15:0] cfg_min_run;
   logic [31:0] cfg_idle_reset;
   logic [31:0] clk_ms;
   bit          sw_running[2];
   logic [31:0] sw_start[2];
   logic [31:0] sw_result[2];
   logic [31:0] sw_stop_at[2];
   bit          sw_stopped[2];
   logic [31:0] sw_toggle_at[2];
   bit          sw_toggled[2];
   logic [31:0] slot_stamp[4];
   bit          slot_alive[4];
   bit          slot_wait[4];
   logic [31:0] check_at;
   bit          check_done;

   task automatic flag_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      error_count++;
   endtask

   function automatic status_type predict_status(stopwatch_cmd_type c);
      status_type  s;
      logic [31:0] span;
      int          i;
      int          ch;
      int          slot;
      s  = '0;
      ch = c.channel;
      case (c.func)
         FUNC_TICK: begin
            clk_ms = clk_ms + 32'd1;
            span = clk_ms - check_at;
            if (!check_done || span >= 32'(cfg_ping_interval)) begin
               check_at   = clk_ms;
               check_done = 1'b1;
               for (i = 0; i < 4; i++) begin
                  span = clk_ms - slot_stamp[i];
                  if (slot_alive[i] && span > 32'(cfg_ping_interval) + PING_GRACE_MS)
                     slot_alive[i] = 1'b0;
               end
            end
            for (i = 0; i < 2; i++) begin
               span = clk_ms - sw_stop_at[i];
               if (sw_stopped[i] && span > cfg_idle_reset) begin
                  sw_running[i] = 1'b0;
                  sw_result[i]  = '0;
                  sw_stopped[i] = 1'b0;
               end
            end
         end
         FUNC_TOGGLE: begin
            span = clk_ms - sw_toggle_at[ch];
            if (!(sw_toggled[ch] && span < 32'(cfg_toggle_lockout))) begin
               sw_toggle_at[ch] = clk_ms;
               sw_toggled[ch]   = 1'b1;
               if (sw_running[ch]) begin
                  // toggle stop ignores the minimum run time
                  sw_result[ch]  = clk_ms - sw_start[ch];
                  sw_stop_at[ch] = clk_ms;
                  sw_stopped[ch] = 1'b1;
                  sw_running[ch] = 1'b0;
               end else begin
                  sw_running[ch] = 1'b1;
                  sw_start[ch]   = clk_ms;
                  sw_stopped[ch] = 1'b0;
               end
            end
         end
         FUNC_SET: begin
            span = clk_ms - sw_start[ch];
            if (c.stop_req) begin
               if (sw_running[ch] && span >= 32'(cfg_min_run)) begin
                  sw_result[ch]  = span;
                  sw_stop_at[ch] = clk_ms;
                  sw_stopped[ch] = 1'b1;
                  sw_running[ch] = 1'b0;
               end
            end else if (!sw_running[ch]) begin
               sw_running[ch] = 1'b1;
               sw_start[ch]   = clk_ms;
               sw_stopped[ch] = 1'b0;
            end
         end
         FUNC_RESET: begin
            for (i = 0; i < 2; i++) begin
               if (c.all_channels || i == ch) begin
                  sw_running[i] = 1'b0;
                  sw_result[i]  = '0;
                  sw_stopped[i] = 1'b0;
               end
            end
         end
         FUNC_PING: begin
            slot = ch * 2 + int'(c.stop_req);
            slot_stamp[slot] = clk_ms;
            slot_alive[slot] = 1'b1;
            slot_wait[slot]  = c.waiting;
         end
         default: ;
      endcase
      s.running_mask = {sw_running[1], sw_running[0]};
      s.time_ch0 = sw_running[0] ? clk_ms - sw_start[0] : sw_result[0];
      s.time_ch1 = sw_running[1] ? clk_ms - sw_start[1] : sw_result[1];
      for (i = 0; i < 4; i++) begin
         s.present_mask[i] = slot_alive[i];
         s.waiting_mask[i] = slot_alive[i] && slot_wait[i];
      end
      return s;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!req_if.valid || req_taken) begin
         if (cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_cmd = cmd_q.pop_front();
            req_if.valid        <= 1'b1;
            req_if.func         <= next_cmd.func;
            req_if.channel      <= next_cmd.channel;
            req_if.stop_req     <= next_cmd.stop_req;
            req_if.waiting      <= next_cmd.waiting;
            req_if.all_channels <= next_cmd.all_channels;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response back-pressure, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_off_request) begin
         rsp_if.ready <= 1'b0;
         hold_left = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // monitor: predict on request accept, check on status accept
   always @(posedge clock) begin
      cycle_count++;
      req_taken = !reset && req_if.valid && req_if.ready;
      if (req_taken) begin
         taken_cmd = {req_if.func, req_if.channel, req_if.stop_req, req_if.waiting,
                      req_if.all_channels};
         expected_status_q.push_back(predict_status(taken_cmd));
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_status = {rsp_if.running_mask, rsp_if.time_ch0, rsp_if.time_ch1,
                       rsp_if.present_mask, rsp_if.waiting_mask};
         if (expected_status_q.size() == 0) begin
            flag_mismatch("status transaction with none outstanding");
         end else begin
            want_status = expected_status_q.pop_front();
            if (got_status.running_mask !== want_status.running_mask)
               flag_mismatch($sformatf("running_mask got %b exp %b",
                             got_status.running_mask, want_status.running_mask));
            if (got_status.time_ch0 !== want_status.time_ch0)
               flag_mismatch($sformatf("time_ch0 got %0d exp %0d",
                             got_status.time_ch0, want_status.time_ch0));
            if (got_status.time_ch1 !== want_status.time_ch1)
               flag_mismatch($sformatf("time_ch1 got %0d exp %0d",
                             got_status.time_ch1, want_status.time_ch1));
            if (got_status.present_mask !== want_status.present_mask)
               flag_mismatch($sformatf("present_mask got %b exp %b",
                             got_status.present_mask, want_status.present_mask));
            if (got_status.waiting_mask !== want_status.waiting_mask)
               flag_mismatch($sformatf("waiting_mask got %b exp %b",
                             got_status.waiting_mask, want_status.waiting_mask));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic push_cmd(logic [2:0] func, logic channel, logic stop_req, logic waiting,
                           logic all_channels);
      cmd_q.push_back({func, channel, stop_req, waiting, all_channels});
   endtask

   function automatic stopwatch_cmd_type random_cmd();
      stopwatch_cmd_type c;
      int                pick;
      c    = stopwatch_cmd_type'($bits(stopwatch_cmd_type)'($urandom));
      pick = $urandom_range(99);
      if (pick < 40)      c.func = FUNC_TICK;
      else if (pick < 55) c.func = FUNC_TOGGLE;
      else if (pick < 70) c.func = FUNC_SET;
      else if (pick < 78) c.func = FUNC_RESET;
      else if (pick < 94) c.func = FUNC_PING;
      else                c.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      return c;
   endfunction

   // all pending transactions through, then let the pipeline settle
   task automatic wait_until_drained();
      while (cmd_q.size() != 0 || req_if.valid || expected_status_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PING_INTERVAL:  cfg_ping_interval  = value[15:0];
         CSR_TOGGLE_LOCKOUT: cfg_toggle_lockout = value[15:0];
         CSR_MIN_RUN:        cfg_min_run        = value[15:0];
         CSR_IDLE_RESET:     cfg_idle_reset     = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(logic [15:0] ping, logic [15:0] lockout, logic [15:0] min_run,
                                 logic [31:0] idle);
      write_register(CSR_PING_INTERVAL, {16'd0, ping});
      write_register(CSR_TOGGLE_LOCKOUT, {16'd0, lockout});
      write_register(CSR_MIN_RUN, {16'd0, min_run});
      write_register(CSR_IDLE_RESET, idle);
   endtask

   // random traffic: mostly single commands, with runs of ticks to age the timers
   task automatic run_phase(int count, int burst_max, int idle_pct, int stall_pct);
      int made;
      int k;
      int run_len;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) == 0) begin
            run_len = $urandom_range(burst_max, 2);
            for (k = 0; k < run_len; k++)
               push_cmd(FUNC_TICK, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            made += run_len;
         end else begin
            cmd_q.push_back(random_cmd());
            made++;
         end
      end
      wait_until_drained();
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.func         = '0;
      req_if.channel      = 1'b0;
      req_if.stop_req     = 1'b0;
      req_if.waiting      = 1'b0;
      req_if.all_channels = 1'b0;
      rsp_if.ready        = 1'b0;

      cfg_ping_interval  = PING_INTERVAL_RST;
      cfg_toggle_lockout = TOGGLE_LOCKOUT_RST;
      cfg_min_run        = MIN_RUN_RST;
      cfg_idle_reset     = IDLE_RESET_RST;
      clk_ms     = '0;
      check_at   = '0;
      check_done = 1'b0;
      for (int i = 0; i < 2; i++) begin
         sw_running[i]   = 1'b0;
         sw_start[i]     = '0;
         sw_result[i]    = '0;
         sw_stop_at[i]   = '0;
         sw_stopped[i]   = 1'b0;
         sw_toggle_at[i] = '0;
         sw_toggled[i]   = 1'b0;
      end
      for (int i = 0; i < 4; i++) begin
         slot_stamp[i] = '0;
         slot_alive[i] = 1'b0;
         slot_wait[i]  = 1'b0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset settings: lockout, minimum run, unused codes, clears
      push_cmd(FUNC_PING,   1'b0, 1'b0, 1'b1, 1'b0);
      push_cmd(FUNC_PING,   1'b1, 1'b1, 1'b0, 1'b1);
      push_cmd(FUNC_TOGGLE, 1'b0, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_TOGGLE, 1'b0, 1'b1, 1'b1, 1'b1);
      push_cmd(FUNC_SET,    1'b1, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_SET,    1'b1, 1'b0, 1'b1, 1'b1);
      push_cmd(FUNC_SET,    1'b1, 1'b1, 1'b0, 1'b0);
      push_cmd(FUNC_TICK,   1'b1, 1'b1, 1'b1, 1'b1);
      push_cmd(FUNC_TOGGLE, 1'b1, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_SET,    1'b0, 1'b1, 1'b0, 1'b0);
      push_cmd(FUNC_RESET,  1'b1, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_SPARE_LO,        1'b1, 1'b1, 1'b1, 1'b1);
      push_cmd(FUNC_SPARE_LO + 3'd1, 1'b0, 1'b1, 1'b0, 1'b1);
      push_cmd(FUNC_SPARE_HI,        1'b1, 1'b0, 1'b1, 1'b0);
      push_cmd(FUNC_RESET,  1'b0, 1'b0, 1'b0, 1'b1);
      push_cmd(FUNC_SET,    1'b0, 1'b1, 1'b0, 1'b0);
      wait_until_drained();

      // directed, zero intervals: check on every tick, clear on the next tick
      apply_settings(16'd0, 16'd0, 16'd0, 32'd0);
      push_cmd(FUNC_TOGGLE, 1'b0, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_TICK,   1'b0, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_TOGGLE, 1'b0, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_SET,    1'b1, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_SET,    1'b1, 1'b1, 1'b0, 1'b0);
      push_cmd(FUNC_TICK,   1'b0, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_PING,   1'b1, 1'b0, 1'b1, 1'b0);
      push_cmd(FUNC_TICK,   1'b0, 1'b0, 1'b0, 1'b0);
      push_cmd(FUNC_TICK,   1'b1, 1'b1, 1'b1, 1'b1);
      wait_until_drained();

      // short timers, no idling, with one long response hold-off to fill the pipe
      apply_settings(16'd3, 16'd2, 16'd6, 32'd25);
      hold_off_request = 1'b1;
      run_phase(100, 30, 0, 0);

      apply_settings(16'd1, 16'd0, 16'd0, 32'd1);
      run_phase(90, 8, 88, 0);

      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      run_phase(70, 40, 0, 88);

      apply_settings(16'($urandom_range(12, 1)), 16'($urandom_range(8, 0)),
                     16'($urandom_range(15, 0)), 32'($urandom_range(40, 1)));
      run_phase(100, 30, 17, 17);

      apply_settings(16'($urandom_range(12, 1)), 16'($urandom_range(8, 0)),
                     16'($urandom_range(15, 0)), 32'($urandom_range(40, 1)));
      run_phase(90, 30, 0, 0);

      apply_settings(16'd2, 16'd1, 16'd4, 32'd10);
      run_phase(80, 20, 17, 17);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/dspt_pkg.sv
rtl/dspt_req_if.sv
rtl/dspt_rsp_if.sv
rtl/dspt_chan.sv
rtl/dspt_presence.sv
rtl/dual_stopwatch_presence_timer_unit.sv
rtl/dspt_checker.sv
sim/tb_dual_stopwatch_presence_timer_unit.sv
